// File: src/tce_pkg.sv
// Shared types and opcodes for the toy CPU execute stage.
package tce_pkg;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0,
    OP_MOV  = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_MUL  = 4'd4,
    OP_LD   = 4'd5,
    OP_SW   = 4'd6,
    OP_CMP  = 4'd7,
    OP_BLE  = 4'd8,
    OP_JUMP = 4'd9
  } tce_op_t;

  localparam int PC_W   = 8;
  localparam int DVAL_W = 16;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] opnd_sel;
    logic [7:0] dest;
    logic [7:0] src;
  } tce_req_t;

  typedef struct packed {
    logic              redirect;
    logic              halted;
    logic [PC_W-1:0]   new_pc;
    logic              le_flag;
    logic              addr_error;
    logic [DVAL_W-1:0] dest_value;
  } tce_rsp_t;

  typedef struct packed {
    logic wen;
    logic is_load;
    logic le_wr;
    logic le_val;
    logic pc_wr;
    logic halt_set;
    logic mem_we;
    logic addr_err;
    logic redirect;
  } tce_ctrl_t;

endpackage

// File: src/tce_alu.sv
// Operand select, arithmetic, compare and control decode for one instruction.
module tce_alu import tce_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int MEM_WORDS = 256
) (
  input  logic [3:0]           op,
  input  logic                 imm,
  input  logic [7:0]           src,
  input  logic [WORD_BITS-1:0] rd,
  input  logic [WORD_BITS-1:0] rs,
  input  logic                 le_cur,
  output logic [WORD_BITS-1:0] result,
  output tce_ctrl_t            ctrl
);

  logic [WORD_BITS-1:0]      imm_val;
  logic [WORD_BITS-1:0]      operand;
  logic [WORD_BITS-1:0]      product;
  logic signed [WORD_BITS:0] left;
  logic signed [WORD_BITS:0] right;
  logic                      in_range;

  assign imm_val  = WORD_BITS'(src);
  assign operand  = imm ? imm_val : rs;
  assign product  = rd * operand;
  assign left     = {rd[WORD_BITS-1], rd};
  assign right    = imm ? {1'b0, imm_val} : {rs[WORD_BITS-1], rs};
  assign in_range = 33'(rs) < 33'(MEM_WORDS);

  always_comb begin
    ctrl   = '0;
    result = operand;
    case (op)
      OP_HALT: begin
        ctrl.halt_set = 1'b1;
        ctrl.redirect = 1'b1;
      end
      OP_MOV: begin
        ctrl.wen = 1'b1;
      end
      OP_ADD: begin
        ctrl.wen = 1'b1;
        result   = rd + operand;
      end
      OP_SUB: begin
        ctrl.wen = 1'b1;
        result   = rd - operand;
      end
      OP_MUL: begin
        ctrl.wen = 1'b1;
        result   = product;
      end
      OP_LD: begin
        if (imm) begin
          ctrl.wen = 1'b1;
          result   = imm_val;
        end else if (in_range) begin
          ctrl.wen     = 1'b1;
          ctrl.is_load = 1'b1;
        end else begin
          ctrl.addr_err = 1'b1;
        end
      end
      OP_SW: begin
        if (in_range) begin
          ctrl.mem_we = 1'b1;
        end else begin
          ctrl.addr_err = 1'b1;
        end
      end
      OP_CMP: begin
        ctrl.le_wr  = 1'b1;
        ctrl.le_val = (left <= right);
      end
      OP_BLE: begin
        if (le_cur) begin
          ctrl.pc_wr    = 1'b1;
          ctrl.redirect = 1'b1;
        end
      end
      OP_JUMP: begin
        ctrl.pc_wr    = 1'b1;
        ctrl.redirect = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/tce_obuf.sv
// Two-entry output queue between the pipeline and the response channel.
module tce_obuf import tce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tce_rsp_t push_data,
  output logic     room,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tce_rsp_t rsp
);

  tce_rsp_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = rsp_valid && rsp_ready;
  assign room      = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/toy_cpu_execute_stage.sv
// Top level of the toy CPU execute stage.
//
// One decoded instruction enters per request on req (req_valid/req_ready) and
// one response leaves per instruction on rsp (rsp_valid/rsp_ready), in order.
// Pipeline: accept (register file read), execute (ALU, flags, pc, data memory
// read or store), write back, then a two-entry output queue. Each instruction
// passes the stage 1 and write back registers and the output queue before its
// response leaves; one request is taken every cycle while the output queue has room.
// Register values are forwarded from write back, and a store lands before
// the next load reads, so dependent instructions issue back to back.
// Reset clears flags and pc at once, then runs a clearing pass over the
// register file and data memory at indices 0 to max(NUM_REGS, MEM_WORDS) - 1
// (0 to 255 at the default sizes), during which req_ready stays low.
// When rsp_ready is held low the queue fills with up to two responses,
// after which the whole pipeline holds and req_ready drops.
module toy_cpu_execute_stage import tce_pkg::*; #(
  parameter int NUM_REGS  = 8,
  parameter int MEM_WORDS = 256,
  parameter int WORD_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tce_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tce_rsp_t rsp
);

  localparam int RI_W  = $clog2(NUM_REGS);
  localparam int MA_W  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CLR_N = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  logic [WORD_BITS-1:0] reg_file [NUM_REGS];
  logic [WORD_BITS-1:0] data_mem [MEM_WORDS];
  logic [RI_W-1:0]      idx_tbl  [256];

  logic             clr_busy;
  logic [CLR_W-1:0] clr_idx;
  logic             adv;
  logic             accept;

  logic                 valid1;
  logic [3:0]           op1;
  logic                 imm1;
  logic [7:0]           src1;
  logic [7:0]           dest1;
  logic [RI_W-1:0]      di1;
  logic [RI_W-1:0]      si1;
  logic [WORD_BITS-1:0] rd_raw;
  logic [WORD_BITS-1:0] rs_raw;
  logic [WORD_BITS-1:0] rd_fwd;
  logic [WORD_BITS-1:0] rs_fwd;
  logic [WORD_BITS-1:0] alu_res;
  tce_ctrl_t            ctrl;

  logic            halt_bit;
  logic            le_bit;
  logic [PC_W-1:0] prog_counter;
  logic            halt_next;
  logic            le_next;
  logic [PC_W-1:0] pc_next;

  logic [31:0]     rs_wide;
  logic [MA_W-1:0] mem_idx;

  logic                 valid2;
  logic                 wen2;
  logic                 ld2;
  logic [RI_W-1:0]      di2;
  logic [WORD_BITS-1:0] res2;
  logic [WORD_BITS-1:0] rd2;
  logic                 redirect2;
  logic                 halted2;
  logic [PC_W-1:0]      pc2;
  logic                 le2;
  logic                 err2;
  logic [WORD_BITS-1:0] mem_q;

  logic                 wb_en;
  logic [WORD_BITS-1:0] wb_val;
  logic                 lw_valid;
  logic [RI_W-1:0]      lw_idx;
  logic [WORD_BITS-1:0] lw_data;

  logic                 rf_we;
  logic [RI_W-1:0]      rf_waddr;
  logic [WORD_BITS-1:0] rf_wdata;
  logic                 dm_we;
  logic [MA_W-1:0]      dm_waddr;
  logic [WORD_BITS-1:0] dm_wdata;

  logic [31:0] dval_wide;
  tce_rsp_t    rsp_s2;
  logic        ob_room;

  for (genvar g = 0; g < 256; g++) begin : g_idx
    assign idx_tbl[g] = RI_W'(g % NUM_REGS);
  end

  assign adv       = ob_room;
  assign req_ready = adv && !clr_busy;
  assign accept    = req_valid && req_ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == CLR_W'(CLR_N - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // register file: two sync read ports, one write port
  assign wb_en    = valid2 && wen2;
  assign wb_val   = ld2 ? mem_q : res2;
  assign rf_we    = clr_busy ? (32'(clr_idx) < NUM_REGS) : (adv && wb_en);
  assign rf_waddr = clr_busy ? clr_idx[RI_W-1:0] : di2;
  assign rf_wdata = clr_busy ? '0 : wb_val;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      reg_file[rf_waddr] <= rf_wdata;
    end
    if (adv) begin
      rd_raw <= reg_file[idx_tbl[req.dest]];
      rs_raw <= reg_file[idx_tbl[req.src]];
    end
  end

  // stage 1 request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= req.op;
      imm1  <= (req.opnd_sel != 8'd0);
      src1  <= req.src;
      dest1 <= req.dest;
      di1   <= idx_tbl[req.dest];
      si1   <= idx_tbl[req.src];
    end
  end

  // forward the write in flight, then the write that just landed
  always_comb begin
    if (wb_en && di2 == di1) begin
      rd_fwd = wb_val;
    end else if (lw_valid && lw_idx == di1) begin
      rd_fwd = lw_data;
    end else begin
      rd_fwd = rd_raw;
    end
    if (wb_en && di2 == si1) begin
      rs_fwd = wb_val;
    end else if (lw_valid && lw_idx == si1) begin
      rs_fwd = lw_data;
    end else begin
      rs_fwd = rs_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (adv && wb_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wb_en) begin
      lw_idx  <= di2;
      lw_data <= wb_val;
    end
  end

  tce_alu #(
    .WORD_BITS (WORD_BITS),
    .MEM_WORDS (MEM_WORDS)
  ) u_alu (
    .op     (op1),
    .imm    (imm1),
    .src    (src1),
    .rd     (rd_fwd),
    .rs     (rs_fwd),
    .le_cur (le_bit),
    .result (alu_res),
    .ctrl   (ctrl)
  );

  assign halt_next = halt_bit | ctrl.halt_set;
  assign le_next   = ctrl.le_wr ? ctrl.le_val : le_bit;
  assign pc_next   = ctrl.pc_wr ? dest1 : prog_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_bit     <= 1'b0;
      le_bit       <= 1'b0;
      prog_counter <= '0;
    end else if (adv && valid1) begin
      halt_bit     <= halt_next;
      le_bit       <= le_next;
      prog_counter <= pc_next;
    end
  end

  // data memory: sync read for loads, store from stage 1
  assign rs_wide  = 32'(rs_fwd);
  assign mem_idx  = rs_wide[MA_W-1:0];
  assign dm_we    = clr_busy ? (32'(clr_idx) < MEM_WORDS) : (adv && valid1 && ctrl.mem_we);
  assign dm_waddr = clr_busy ? clr_idx[MA_W-1:0] : mem_idx;
  assign dm_wdata = clr_busy ? '0 : rd_fwd;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (adv) begin
      mem_q <= data_mem[mem_idx];
    end
  end

  // stage 2: write back
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wen2      <= ctrl.wen;
      ld2       <= ctrl.is_load;
      di2       <= di1;
      res2      <= alu_res;
      rd2       <= rd_fwd;
      redirect2 <= ctrl.redirect;
      halted2   <= halt_next;
      pc2       <= pc_next;
      le2       <= le_next;
      err2      <= ctrl.addr_err;
    end
  end

  assign dval_wide = 32'(wen2 ? wb_val : rd2);

  always_comb begin
    rsp_s2            = '0;
    rsp_s2.redirect   = redirect2;
    rsp_s2.halted     = halted2;
    rsp_s2.new_pc     = pc2;
    rsp_s2.le_flag    = le2;
    rsp_s2.addr_error = err2;
    rsp_s2.dest_value = dval_wide[DVAL_W-1:0];
  end

  tce_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && valid2),
    .push_data (rsp_s2),
    .room      (ob_room),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !valid1 && !valid2)
    else $error("instruction in flight during clearing pass");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_bit |=> halt_bit)
    else $error("halt flag dropped without reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid2 && !adv |=> valid2 && $stable(di2) && $stable(wen2))
    else $error("write back stage changed while stalled");

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    adv && valid1 && ctrl.mem_we |-> (rs_wide < 32'(MEM_WORDS)))
    else $error("store issued out of memory range");

endmodule
